@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

// Same-cycle implication that is also checked around reset.
`define ASSERT_IMP_NR(label, clk, a, c, msg) \
  label: assert property (@(posedge clk) (a) |-> (c)) \
    else $error(msg);

`endif

@@ hw/rtl/nes_pkg.sv @@
// ----------------------------------------------------------------------------
// nes_pkg
// Constants and types for the next even smooth size block.
// ----------------------------------------------------------------------------
package nes_pkg;

  // Request bits that take part in the search; the limit is 2^(INPUT_BITS-1).
  localparam int INPUT_BITS = 32;
  // Fixed width of the request and result ports.
  localparam int PORT_BITS = 32;

  // Counts the even 5-smooth numbers up to 2^(ib-1), evaluated at elaboration.
  function automatic int smooth_count(int ib);
    longint unsigned lim;
    longint unsigned p5;
    longint unsigned v;
    longint unsigned w;
    int cnt;
    lim = 64'd1 << (ib - 1);
    cnt = 0;
    for (p5 = 64'd2; p5 <= lim; p5 = p5 * 64'd5) begin
      for (v = p5; v <= lim; v = v * 64'd3) begin
        for (w = v; w <= lim; w = w * 64'd2) begin
          cnt = cnt + 1;
        end
      end
    end
    return cnt;
  endfunction

  localparam int TABLE_DEPTH = smooth_count(INPUT_BITS);
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  // Fill candidates reach five times the limit.
  localparam int CAND_BITS   = INPUT_BITS + 2;

  typedef logic [INPUT_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CAND_BITS-1:0]  cand_t;

  localparam addr_t  LAST_ADDR   = addr_t'(TABLE_DEPTH - 1);
  localparam addr_t  MID_FIRST   = addr_t'((TABLE_DEPTH - 1) / 2);
  localparam value_t FIRST_VALUE = value_t'(2);

endpackage

@@ hw/rtl/nes_ram.sv @@
// ----------------------------------------------------------------------------
// nes_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/next_even_smooth_size.sv @@
// ----------------------------------------------------------------------------
// next_even_smooth_size
// A request is accepted in S_IDLE, searched in S_SEARCH (one binary search
// step per cycle on the RAM port) and handed over from S_FETCH. The next
// item is taken while a result still waits in the output register; a second
// result stalls in the fetch step.
// Reset: the table is rebuilt in RAM; req_ready stays low until it is done.
// ----------------------------------------------------------------------------
module next_even_smooth_size (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [nes_pkg::PORT_BITS-1:0] requested_size,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [nes_pkg::PORT_BITS-1:0] smooth_size
);

  import nes_pkg::*;

  // The RAM holds every even 5-smooth number up to the limit, in ascending
  // order. After reset it is generated with the classic three-pointer merge:
  // the next entry is the least of 2*e[p2], 3*e[p3] and 5*e[p5], and each
  // pointer whose product matched advances and rereads the table.
  // A request is then served by a lower-bound binary search over the table.

  typedef enum logic [2:0] {
    S_FILL_INIT,
    S_FILL_GEN,
    S_FILL_RD,
    S_FILL_MUL,
    S_IDLE,
    S_SEARCH,
    S_FETCH
  } state_t;

  typedef enum logic [1:0] {
    F_TWO,
    F_THREE,
    F_FIVE
  } factor_t;

  localparam cand_t C2_FIRST = cand_t'(4);
  localparam cand_t C3_FIRST = cand_t'(6);
  localparam cand_t C5_FIRST = cand_t'(10);

  state_t  state;
  addr_t   wr_count;
  addr_t   ptr2, ptr3, ptr5;
  cand_t   c2, c3, c5;
  logic    pend2, pend3, pend5;
  factor_t sel;
  value_t  req_val;
  addr_t   lo, hi, mid;

  logic   ram_we;
  addr_t  ram_waddr;
  value_t ram_wdata;
  addr_t  ram_raddr;
  value_t ram_rdata;

  nes_ram #(
    .WIDTH(INPUT_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Only the low INPUT_BITS of the request count; wider settings zero-extend.
  logic [INPUT_BITS+PORT_BITS-1:0] req_wide;
  value_t                          req_in;
  logic [PORT_BITS+INPUT_BITS-1:0] rsp_wide;
  logic [PORT_BITS-1:0]            rsp_next;

  assign req_wide = {{INPUT_BITS{1'b0}}, requested_size};
  assign req_in   = req_wide[INPUT_BITS-1:0];
  assign rsp_wide = {{PORT_BITS{1'b0}}, ram_rdata};
  assign rsp_next = rsp_wide[PORT_BITS-1:0];

  // Smallest of the three merge candidates.
  cand_t m23, cmin;
  assign m23  = (c2 < c3) ? c2 : c3;
  assign cmin = (m23 < c5) ? m23 : c5;

  // Products of the entry just read, as shift-and-add.
  cand_t rd_ext, x2, x3, x5;
  assign rd_ext = cand_t'(ram_rdata);
  assign x2     = rd_ext << 1;
  assign x3     = x2 + rd_ext;
  assign x5     = (rd_ext << 2) + rd_ext;

  // One lower-bound search step on the entry at mid. A table entry below the
  // request moves lo past mid; otherwise mid becomes the new upper bound.
  // A request above the limit ends on the last entry, which is the limit.
  logic               lt;
  addr_t              lo_step, hi_step, mid_step;
  logic [ADDR_BITS:0] mid_sum;

  assign lt       = ram_rdata < req_val;
  assign lo_step  = lt ? (mid + addr_t'(1)) : lo;
  assign hi_step  = lt ? hi : mid;
  assign mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
  assign mid_step = mid_sum[ADDR_BITS:1];

  assign req_ready = (state == S_IDLE);

  // RAM port control. The read address is steered straight from the search
  // step so that the next probe is issued in the same cycle as the compare.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_count;
    ram_wdata = cmin[INPUT_BITS-1:0];
    ram_raddr = lo;
    case (state)
      S_FILL_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = FIRST_VALUE;
      end
      S_FILL_GEN: begin
        ram_we = 1'b1;
      end
      S_FILL_RD: begin
        if (pend2) begin
          ram_raddr = ptr2 + addr_t'(1);
        end else if (pend3) begin
          ram_raddr = ptr3 + addr_t'(1);
        end else begin
          ram_raddr = ptr5 + addr_t'(1);
        end
      end
      S_IDLE: begin
        ram_raddr = MID_FIRST;
      end
      S_SEARCH: begin
        ram_raddr = (lo_step == hi_step) ? lo_step : mid_step;
      end
      S_FETCH: begin
        ram_raddr = lo;
      end
      default: begin
        ram_raddr = lo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL_INIT;
      rsp_valid <= 1'b0;
    end else begin
      // In the fetch step a taken result is replaced by the next one below.
      if (rsp_valid && rsp_ready && (state != S_FETCH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_FILL_INIT: begin
          wr_count <= addr_t'(1);
          ptr2     <= '0;
          ptr3     <= '0;
          ptr5     <= '0;
          c2       <= C2_FIRST;
          c3       <= C3_FIRST;
          c5       <= C5_FIRST;
          state    <= S_FILL_GEN;
        end
        S_FILL_GEN: begin
          // Every candidate equal to the new entry must advance, so that
          // duplicates such as 12 = 2*6 = 3*4 enter the table only once.
          pend2 <= (c2 == cmin);
          pend3 <= (c3 == cmin);
          pend5 <= (c5 == cmin);
          if (wr_count == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            wr_count <= wr_count + addr_t'(1);
            state    <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          // The entry read here was already written in an earlier S_FILL_GEN
          // step, so the RAM returns it.
          if (pend2) begin
            ptr2  <= ptr2 + addr_t'(1);
            pend2 <= 1'b0;
            sel   <= F_TWO;
          end else if (pend3) begin
            ptr3  <= ptr3 + addr_t'(1);
            pend3 <= 1'b0;
            sel   <= F_THREE;
          end else begin
            ptr5  <= ptr5 + addr_t'(1);
            pend5 <= 1'b0;
            sel   <= F_FIVE;
          end
          state <= S_FILL_MUL;
        end
        S_FILL_MUL: begin
          case (sel)
            F_TWO:   c2 <= x2;
            F_THREE: c3 <= x3;
            default: c5 <= x5;
          endcase
          if (pend2 || pend3 || pend5) begin
            state <= S_FILL_RD;
          end else begin
            state <= S_FILL_GEN;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_val <= req_in;
            lo      <= '0;
            hi      <= LAST_ADDR;
            mid     <= MID_FIRST;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          lo  <= lo_step;
          hi  <= hi_step;
          mid <= mid_step;
          if (lo_step == hi_step) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // The read address stays on lo, so the entry holds while waiting.
          if (!rsp_valid || rsp_ready) begin
            smooth_size <= rsp_next;
            rsp_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_FILL_INIT;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/nes_checker.sv @@
// ----------------------------------------------------------------------------
// nes_checker
// Port-level assertions for next_even_smooth_size, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nes_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [nes_pkg::PORT_BITS-1:0] smooth_size
);

  // The table rebuild follows every reset, so no item is taken right after.
  `ASSERT_IMP_NR(a_busy_after_reset, clk, $past(rst) && !rst, !req_ready, "ready right after reset")

  // One item at a time: the block is busy in the cycle after an accept.
  `ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "ready after accept")

  // Every result is an even number.
  `ASSERT_IMP(a_result_even, clk, rst, rsp_valid, !smooth_size[0], "odd result")

  // A stalled result holds its value.
  `ASSERT_NXT(a_result_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(smooth_size), "result dropped")

endmodule

bind next_even_smooth_size nes_checker u_nes_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .smooth_size(smooth_size)
);

@@ sim/next_even_smooth_size_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_even_smooth_size_tb
// Self-checking bench for the next even smooth size block. A queue of
// requests (a directed set, then random sizes biased toward smooth numbers
// and their neighbors) feeds a bursty driver. A monitor with a stalling
// ready pattern predicts each result at accept time and checks it in order.
// ----------------------------------------------------------------------------
module next_even_smooth_size_tb;
  import nes_pkg::*;

  typedef logic [PORT_BITS-1:0] port_word_t;

  // One request waiting to be sent. When hold_for_drain is set, the driver
  // keeps valid low until every earlier request has returned its result.
  typedef struct {
    port_word_t size;
    bit         hold_for_drain;
  } size_req_t;

  // A result still owed by the block, with the request that caused it.
  typedef struct {
    port_word_t request;
    port_word_t smooth;
  } smooth_due_t;

  // Styles of back pressure on the result side.
  typedef enum int {
    ALWAYS_READY,
    COIN_FLIP,
    MOSTLY_STALLED,
    LONG_STALLS
  } ready_style_t;

  localparam int RANDOM_REQUESTS = 1650;
  // Cycles to keep watching after the last result.
  localparam int SETTLE_CYCLES   = 40;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  port_word_t requested_size = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  port_word_t smooth_size;

  size_req_t   requests_to_send[$];
  smooth_due_t sizes_due[$];

  // Both counters change only by nonblocking assignment in the monitor, so
  // any process that reads them at a clock edge sees the value from before it.
  int n_accepted = 0;
  int n_checked  = 0;
  int n_total    = 0;
  int n_directed = 0;
  int mismatch_count = 0;

  // Coverage tallies, taken as requests are accepted.
  int n_small = 0;
  int n_odd   = 0;
  int n_exact = 0;
  int n_over  = 0;

  // Once set, the receiver stops stalling so that a stray result shows up.
  logic wind_down = 1'b0;

  // Sender and receiver pacing state, each used by one block only.
  int           burst_left = 1;
  int           gap_left   = 0;
  ready_style_t ready_style = ALWAYS_READY;
  int           style_left = 0;
  int           stall_left = 0;

  next_even_smooth_size dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .requested_size (requested_size),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .smooth_size    (smooth_size)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Smallest even number of the form 2^a * 3^b * 5^c not below the request.
  // Every odd part 3^b * 5^c gets the least power of two (at least 2) that
  // reaches the request, and the smallest product wins. Requests above the
  // limit 2^(INPUT_BITS-1) saturate to the limit, which is itself smooth.
  function automatic port_word_t smooth_ceiling(port_word_t req);
    longint unsigned limit;
    longint unsigned n;
    longint unsigned best;
    longint unsigned p5;
    longint unsigned odd_part;
    longint unsigned cand;
    limit = 64'd1 << (INPUT_BITS - 1);
    n = 64'(req) & ((64'd1 << INPUT_BITS) - 64'd1);
    if (n > limit) begin
      return port_word_t'(limit);
    end
    best = limit;
    for (p5 = 64'd1; p5 <= limit; p5 = p5 * 64'd5) begin
      for (odd_part = p5; odd_part <= limit; odd_part = odd_part * 64'd3) begin
        cand = odd_part * 64'd2;
        while (cand < n) begin
          cand = cand * 64'd2;
        end
        if (cand < best) begin
          best = cand;
        end
      end
    end
    return port_word_t'(best);
  endfunction

  // A random even smooth number within the limit, built by multiplying in
  // random factors of 2, 3 and 5 that still fit.
  function automatic longint unsigned random_smooth();
    longint unsigned v;
    longint unsigned f;
    int steps;
    v = 64'd2;
    steps = $urandom_range(0, 45);
    repeat (steps) begin
      case ($urandom_range(0, 2))
        0:       f = 64'd2;
        1:       f = 64'd3;
        default: f = 64'd5;
      endcase
      if (v * f <= (64'd1 << (INPUT_BITS - 1))) begin
        v = v * f;
      end
    end
    return v;
  endfunction

  task automatic queue_request(port_word_t sz, bit hold);
    size_req_t r;
    r.size = sz;
    r.hold_for_drain = hold;
    requests_to_send.push_back(r);
  endtask

  // Driver. Valid is held with its payload until accepted. Between bursts of
  // random length the sender goes quiet for a random gap; a gap of zero lets
  // bursts run back to back. A request marked for drain waits until nothing
  // is in flight: either an accept at this edge or a result still owed.
  always @(posedge clk) begin : drive_requests
    size_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        req_valid <= 1'b0;
      end else if (requests_to_send.size() != 0 &&
                   !(requests_to_send[0].hold_for_drain &&
                     (req_valid || n_accepted != n_checked))) begin
        nxt = requests_to_send.pop_front();
        req_valid <= 1'b1;
        requested_size <= nxt.size;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor. The expected result is worked out when the request is accepted
  // and checked, in order, against the next result that the block hands over.
  // The same block paces rsp_ready, switching between back pressure styles.
  always @(posedge clk) begin : watch_results
    smooth_due_t due;
    port_word_t  predicted;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        predicted = smooth_ceiling(requested_size);
        due.request = requested_size;
        due.smooth = predicted;
        sizes_due.push_back(due);
        n_accepted <= n_accepted + 1;
        if (requested_size <= 2) n_small++;
        if (requested_size[0]) n_odd++;
        if (predicted == requested_size) n_exact++;
        if (64'(requested_size) > (64'd1 << (INPUT_BITS - 1))) n_over++;
      end

      if (rsp_valid && rsp_ready) begin
        if (sizes_due.size() == 0) begin
          mismatch_count++;
          $error("smooth_size: no result expected, actual %0d", smooth_size);
        end else begin
          due = sizes_due.pop_front();
          n_checked <= n_checked + 1;
          if (smooth_size !== due.smooth) begin
            mismatch_count++;
            $error("smooth_size for request %0d: expected %0d, actual %0d",
                   due.request, due.smooth, smooth_size);
          end
        end
      end

      if (wind_down) begin
        rsp_ready <= 1'b1;
      end else begin
        if (style_left == 0) begin
          ready_style = ready_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(20, 300);
        end else begin
          style_left = style_left - 1;
        end
        case (ready_style)
          ALWAYS_READY: begin
            rsp_ready <= 1'b1;
          end
          COIN_FLIP: begin
            rsp_ready <= 1'($urandom_range(0, 1));
          end
          MOSTLY_STALLED: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            if (stall_left != 0) begin
              stall_left = stall_left - 1;
              rsp_ready <= 1'b0;
            end else begin
              rsp_ready <= 1'b1;
              if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(5, 30);
              end
            end
          end
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin : run_sequence
    port_word_t directed_sizes[];
    longint unsigned near;
    port_word_t sz;
    int pick;

    // Directed part: the small requests that all give 2, odd and even
    // neighbors of low smooth numbers, the limit and its neighbors, requests
    // above the limit up to all ones, alternating bit patterns, and twice
    // large powers of three and five with the next request above each.
    directed_sizes = {
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
      32'd11, 32'd13, 32'd15, 32'd16, 32'd17,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
      32'h5555_5555, 32'hAAAA_AAAA,
      32'd774840978, 32'd774840979, 32'd488281250, 32'd488281251
    };
    foreach (directed_sizes[i]) begin
      queue_request(directed_sizes[i], 1'b0);
    end
    n_directed = directed_sizes.size();

    // Random part. Almost half sit on or right next to a smooth number,
    // where an off-by-one in the search shows. The rest spread over the
    // whole 32-bit range, over every magnitude, over tiny sizes, and around
    // the limit. The first random request waits for the directed part to
    // drain completely, and now and then another one does the same.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        near = random_smooth() + 64'($urandom_range(0, 6));
        near = (near >= 64'd3) ? near - 64'd3 : 64'd0;
        sz = port_word_t'(near);
      end else if (pick < 65) begin
        sz = $urandom;
      end else if (pick < 85) begin
        sz = $urandom >> $urandom_range(0, 31);
      end else if (pick < 95) begin
        sz = $urandom_range(0, 64);
      end else begin
        sz = 32'h8000_0000 + $urandom_range(0, 64) - 32'd32;
      end
      queue_request(sz, (i == 0) || ($urandom_range(0, 99) == 0));
    end
    n_total = requests_to_send.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The block rebuilds its table after reset with req_ready low; the
    // driver simply waits on the handshake.
    while (n_accepted != n_total) @(posedge clk);
    while (n_checked != n_accepted) @(posedge clk);
    wind_down <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);

    if (sizes_due.size() != 0) begin
      mismatch_count++;
      $error("smooth_size: %0d expected results never arrived", sizes_due.size());
    end

    $display("Checked %0d results for %0d requests (%0d directed, %0d random).",
             n_checked, n_total, n_directed, n_total - n_directed);
    $display("Requests of 2 or less: %0d, odd: %0d, already smooth: %0d, above limit: %0d.",
             n_small, n_odd, n_exact, n_over);
    if (mismatch_count == 0) begin
      $display("next_even_smooth_size_tb passed");
    end else begin
      $display("next_even_smooth_size_tb failed");
    end
    $finish;
  end

  // Watchdog. A correct run finishes before this limit even with the longest
  // gaps and stalls on every item, including the table rebuild after reset.
  initial begin : watchdog
    #1_000_000;
    $display("next_even_smooth_size_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/nes_pkg.sv
hw/rtl/nes_ram.sv
hw/rtl/next_even_smooth_size.sv
hw/rtl/nes_checker.sv
sim/next_even_smooth_size_tb.sv
